>>> src/cfsd_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 frame sync package
// Shared constants, types and the CRC-8 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package cfsd_pkg;

    // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final xor
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;

    // Window of held bytes ahead of the CRC byte
    localparam int         WIN_DEPTH  = 3;
    localparam logic [1:0] WIN_FULL   = 2'd3;

    // Reset value of the frames-to-sync register
    localparam logic [3:0] SYNC_RESET = 4'd2;

    typedef logic [7:0] t_byte;

    // Result of one window step
    typedef struct packed {
        logic        valid;
        logic [7:0]  code;
        logic [15:0] value;
    } t_frame;

    // Window status seen before a step
    typedef struct packed {
        logic [1:0] fill;
        logic [3:0] good_cnt;
    } t_win_status;

    // One byte through the CRC-8 register (linear, flattens to an XOR net)
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/cfsd_if.sv
// ----------------------------------------------------------------------------
// CRC-8 frame sync stream interfaces
// Valid/ready channels for received bytes and for decoded frames.
// ----------------------------------------------------------------------------
interface cfsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfsd_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_code;
    logic [15:0] frame_value;

    modport source (output valid, output frame_code, output frame_value, input ready);
    modport sink   (input valid, input frame_code, input frame_value, output ready);
endinterface

>>> src/cfsd_crc8.sv
// ----------------------------------------------------------------------------
// CRC-8 over three bytes
// Combinational CRC-8 of the held window, starting from the initial value.
// ----------------------------------------------------------------------------
module cfsd_crc8 (
    input  logic [7:0] i_b0,
    input  logic [7:0] i_b1,
    input  logic [7:0] i_b2,
    output logic [7:0] o_crc
);

    logic [7:0] crc0;
    logic [7:0] crc1;

    // Run the three bytes through in order
    assign crc0  = cfsd_pkg::crc8_update(cfsd_pkg::CRC_INIT, i_b0);
    assign crc1  = cfsd_pkg::crc8_update(crc0, i_b1);
    assign o_crc = cfsd_pkg::crc8_update(crc1, i_b2);

endmodule

>>> src/cfsd_window.sv
// ----------------------------------------------------------------------------
// CRC-8 frame sync window
// Holds up to three bytes, checks the fourth against their CRC and tracks
// the good-frame count that gates frame emission.
// ----------------------------------------------------------------------------
module cfsd_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic [3:0]            i_frames_to_sync,
    output cfsd_pkg::t_frame      o_result,
    output cfsd_pkg::t_win_status o_status
);

    cfsd_pkg::t_byte r_win [cfsd_pkg::WIN_DEPTH];
    cfsd_pkg::t_byte n_win [cfsd_pkg::WIN_DEPTH];
    logic [1:0]      r_fill;
    logic [1:0]      n_fill;
    logic [3:0]      r_good_cnt;
    logic [3:0]      n_good_cnt;
    logic [7:0]      crc;
    logic            full;
    logic            match;

    cfsd_crc8 u_crc8 (
        .i_b0  (r_win[0]),
        .i_b1  (r_win[1]),
        .i_b2  (r_win[2]),
        .o_crc (crc)
    );

    assign full  = (r_fill == cfsd_pkg::WIN_FULL);
    assign match = (crc == i_byte);

    // Decide the next window state and whether a frame comes out
    always_comb begin
        n_win          = r_win;
        n_fill         = r_fill;
        n_good_cnt     = r_good_cnt;
        o_result.valid = 1'b0;
        o_result.code  = r_win[0];
        o_result.value = {r_win[2], r_win[1]};
        if (i_step) begin
            if (!full) begin
                // append to the window
                n_win[r_fill] = i_byte;
                n_fill        = r_fill + 2'd1;
            end else if (match) begin
                // good frame: emit once in sync, otherwise count it
                if (r_good_cnt >= i_frames_to_sync) begin
                    o_result.valid = 1'b1;
                end else begin
                    n_good_cnt = r_good_cnt + 4'd1;
                end
                n_fill = 2'd0;
            end else begin
                // lost sync: drop the oldest byte and slide
                n_good_cnt = 4'd0;
                n_win[0]   = r_win[1];
                n_win[1]   = r_win[2];
                n_win[2]   = i_byte;
            end
        end
    end

    // Hold the window bytes
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    // Advance fill level and good-frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= 2'd0;
            r_good_cnt <= 4'd0;
        end else begin
            r_fill     <= n_fill;
            r_good_cnt <= n_good_cnt;
        end
    end

    assign o_status.fill     = r_fill;
    assign o_status.good_cnt = r_good_cnt;

endmodule

>>> src/crc8_frame_sync_deframer.sv
// ----------------------------------------------------------------------------
// CRC-8 frame sync deframer
// Path: a byte accepted into the input register is checked by the window step
//   once the result register is free; a frame it completes is registered in
//   the result register and presented on o_frame until the sink takes it.
// Throughput: one byte per cycle while the result register is free, set by
//   the window step between the input register and the result register.
// Reset: synchronous active low; empties the window, clears the good-frame
//   count and loads frames_to_sync with 2.
// ----------------------------------------------------------------------------
module crc8_frame_sync_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata,
    cfsd_byte_if.sink           i_rx,
    cfsd_frame_if.source        o_frame
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    logic [7:0]            r_out_code;
    logic [15:0]           r_out_value;
    logic [3:0]            r_frames_to_sync;
    logic                  out_free;
    logic                  advance;
    cfsd_pkg::t_frame      win_result;
    cfsd_pkg::t_win_status win_status;

    // Handshake: the stage moves on whenever the result slot can take it
    assign out_free    = !r_out_valid || o_frame.ready;
    assign advance     = r_in_valid && out_free;
    assign i_rx.ready  = !r_in_valid || advance;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_to_sync <= cfsd_pkg::SYNC_RESET;
        end else if (i_cfg_we) begin
            r_frames_to_sync <= i_cfg_wdata;
        end
    end

    // Input register: capture each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    cfsd_window u_window (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_byte           (r_in_byte),
        .i_frames_to_sync (r_frames_to_sync),
        .o_result         (win_result),
        .o_status         (win_status)
    );

    // Result register: hold until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && win_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && win_result.valid) begin
            r_out_code  <= win_result.code;
            r_out_value <= win_result.value;
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.frame_code  = r_out_code;
    assign o_frame.frame_value = r_out_value;

    // A frame only comes out of a full window
    a_result_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_result.valid |-> (win_status.fill == cfsd_pkg::WIN_FULL))
        else $error("frame produced from a partial window");

    // A frame is only emitted once the count has reached the threshold
    a_result_in_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_result.valid |-> (win_status.good_cnt >= r_frames_to_sync))
        else $error("frame emitted while out of sync");

    // A new output transaction must come from a byte held in the stage
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("output raised without a byte in the stage");

    // An empty stage always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_rx.ready)
        else $error("input stalled with an empty stage");

endmodule
